[design/fdc_pkg.sv]
package fdc_pkg;

  localparam int ImageDepth  = 262144;
  localparam int ImageAw     = $clog2(ImageDepth);
  localparam int SectorsPerTrack = 9;
  localparam int SectorBytes = 512;
  localparam int TrackStride = SectorsPerTrack * SectorBytes + 256;
  localparam int HeaderLen   = 7;

  typedef enum logic [1:0] {
    OP_WRITE_DATA  = 2'd0,
    OP_READ_DATA   = 2'd1,
    OP_READ_STATUS = 2'd2,
    OP_LOAD_IMAGE  = 2'd3
  } op_e;

  localparam logic [3:0] CMD_SPECIFY     = 4'd3;
  localparam logic [3:0] CMD_SENSE_DRIVE = 4'd4;
  localparam logic [3:0] CMD_READ_DATA   = 4'd6;
  localparam logic [3:0] CMD_RECAL       = 4'd7;
  localparam logic [3:0] CMD_SENSE_INT   = 4'd8;
  localparam logic [3:0] CMD_READ_ID     = 4'd10;
  localparam logic [3:0] CMD_SEEK        = 4'd15;

  localparam logic [7:0] MS_RQM  = 8'h80;
  localparam logic [7:0] MS_DIO  = 8'h40;
  localparam logic [7:0] MS_BUSY = 8'h10;
  localparam logic [7:0] ST_SEEK_END = 8'h20;

endpackage

[design/fdc_ram.sv]
module fdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

[design/floppy_controller_command_phase.sv]
// Floppy controller register block. One host request is taken each cycle
// that the output is not stalled: data register writes (command and
// parameter bytes), data register reads, main status reads and image byte
// loads. Reads return one byte, data register writes and image loads return
// nothing. The disk image sits in a single-port-write, registered-read RAM;
// a read data sector byte is fetched as its request is taken and is driven
// out next cycle from the RAM, sustaining one request per clock if unstalled.
// Only one request is taken per cycle, so a load never meets a fetch in the
// same cycle; a load taken after a fetch leaves the fetched byte untouched.
// Read data returns seven header bytes then 512 sector bytes from
// cylinder*4864 + sector*512 + 512, modulo the image depth.
module floppy_controller_command_phase
  import fdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  input  logic [31:0] s_axis_tdata,   // write_byte[7:0], image_address[25:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // read_byte[7:0]
);

  logic [1:0]  op;
  logic [7:0]  wb;
  logic [17:0] waddr;
  logic        acc;
  assign op    = s_axis_tuser;
  assign wb    = s_axis_tdata[7:0];
  assign waddr = s_axis_tdata[25:8];

  // state registers
  logic [3:0]  pc_q, pc_d, cmd_q, cmd_d;
  logic [15:0] tim_q, tim_d;
  logic [7:0]  head_q, head_d;
  logic [1:0]  unit_q, unit_d;
  logic [7:0]  pcyl_q, pcyl_d, tcyl_q, tcyl_d, sec_q, sec_d, size_q, size_d;
  logic [23:0] teg_q, teg_d;
  logic [7:0]  st0_q, st0_d, st3_q, st3_d, ms_q, ms_d;
  logic        opp_q, opp_d, ract_q, ract_d;
  logic [9:0]  rrem_q, rrem_d, rpos_q, rpos_d;
  logic [7:0]  hdr_q [HeaderLen];
  logic [7:0]  hdr_d [HeaderLen];
  logic [17:0] base_q, base_d;

  // output stage: skid register plus pending-RAM-data flag
  logic        ov_q, ofetch_q;
  logic [7:0]  obyte_q, fwd_q;
  logic        fwd_hit_q;
  logic [7:0]  ram_rd;
  logic        new_res, new_fetch, fwd_hit;
  logic [7:0]  new_byte;
  logic [17:0] raddr;

  assign s_axis_tready = !ov_q || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;

  fdc_ram #(.Width(8), .Depth(ImageDepth)) u_image (
    .clk_i   (clk_i),
    .we_i    (acc && op == OP_LOAD_IMAGE),
    .waddr_i (waddr[ImageAw-1:0]),
    .wdata_i (wb),
    .raddr_i (raddr[ImageAw-1:0]),
    .rdata_o (ram_rd)
  );

  logic [2:0]  dbits;
  logic [7:0]  v8;
  logic [3:0]  pcn;
  logic [25:0] rd_addr;
  logic [7:0]  sec_inc;
  assign dbits   = {head_q[0], unit_q};
  assign raddr   = base_q + 18'(rpos_q - 10'(HeaderLen));
  assign rd_addr = 26'(tcyl_q) * 26'(TrackStride) + 26'(sec_q) * 26'(SectorBytes) + 26'd512;

  always_comb begin
    pc_d = pc_q; cmd_d = cmd_q; tim_d = tim_q; head_d = head_q; unit_d = unit_q;
    pcyl_d = pcyl_q; tcyl_d = tcyl_q; sec_d = sec_q; size_d = size_q; teg_d = teg_q;
    st0_d = st0_q; st3_d = st3_q; ms_d = ms_q; opp_d = opp_q; ract_d = ract_q;
    rrem_d = rrem_q; rpos_d = rpos_q; hdr_d = hdr_q; base_d = base_q;
    new_res = 1'b0; new_fetch = 1'b0; new_byte = 8'hff;
    v8 = 8'h00; pcn = pc_q + 4'd1; sec_inc = 8'h00;
    if (acc) begin
      case (op)
        OP_WRITE_DATA: begin
          if (pc_q == 4'd0) begin
            if (wb == 8'h03 || wb == 8'h04 || wb == 8'h07) begin
              cmd_d = wb[3:0]; pc_d = 4'd1; ms_d = {4'h0, ms_q[3:0]} | MS_RQM;
              if (wb == 8'h07) opp_d = 1'b1;
            end else if (wb == 8'h08) begin
              cmd_d = CMD_SENSE_INT; pc_d = 4'd0;
              v8 = {5'd0, dbits} | ST_SEEK_END | (opp_q ? 8'h00 : 8'h80);
              st0_d = v8; opp_d = 1'b0; hdr_d[0] = v8; hdr_d[1] = pcyl_q;
              ract_d = 1'b1; rrem_d = 10'd2; rpos_d = 10'd0;
              ms_d = {4'h0, ms_q[3:0]} | MS_RQM | MS_DIO;
            end else if (wb[3:0] == 4'ha) begin
              st0_d = {5'd0, dbits} | ST_SEEK_END | 8'h40; st3_d = ST_SEEK_END;
              cmd_d = CMD_READ_ID; pc_d = 4'd1; opp_d = 1'b1;
              ms_d = {4'h0, ms_q[3:0]} | MS_RQM;
            end else if (wb[3:0] == 4'h6) begin
              cmd_d = CMD_READ_DATA; pc_d = 4'd1; opp_d = 1'b1;
              ms_d = {4'h0, ms_q[3:0]} | MS_RQM;
            end else if (wb == 8'h0f) begin
              cmd_d = CMD_SEEK; pc_d = 4'd1; opp_d = 1'b1;
            end else begin
              pc_d = 4'd0;
            end
          end else begin
            case (cmd_q)
              CMD_SPECIFY: begin
                if (pc_q == 4'd1) tim_d[15:8] = wb;
                if (pc_q == 4'd2) tim_d[7:0] = wb;
                pc_d = pcn;
                if (pcn == 4'd3) begin
                  pc_d = 4'd0; ms_d = {4'h0, ms_q[3:0]} | MS_RQM;
                end
              end
              CMD_SENSE_DRIVE: begin
                if (pc_q == 4'd1) begin
                  head_d = {7'd0, wb[2]}; unit_d = wb[1:0];
                end
                pc_d = pcn;
                if (pcn == 4'd2) begin
                  pc_d = 4'd0;
                  v8 = (unit_d != 2'd0) ? 8'h00 : ST_SEEK_END;
                  st3_d = v8; hdr_d[0] = v8;
                  ract_d = 1'b1; rrem_d = 10'd1; rpos_d = 10'd0;
                  ms_d = {4'h0, ms_q[3:0]} | MS_RQM | MS_DIO | MS_BUSY;
                end
              end
              CMD_READ_DATA: begin
                if (pc_q == 4'd1) begin
                  head_d = {7'd0, wb[2]}; unit_d = wb[1:0];
                end
                if (pc_q == 4'd2) tcyl_d = wb;
                if (pc_q == 4'd3) head_d = wb;
                if (pc_q == 4'd4) sec_d = wb;
                if (pc_q == 4'd5) size_d = wb;
                if (pc_q == 4'd6) teg_d[23:16] = wb;
                if (pc_q == 4'd7) teg_d[15:8] = wb;
                if (pc_q == 4'd8) teg_d[7:0] = wb;
                pc_d = pcn;
                if (pcn == 4'd9) begin
                  // params 2..5 are taken earlier, so registered values are final
                  pc_d = 4'd0;
                  v8 = {5'd0, dbits} | ST_SEEK_END;
                  st0_d = v8;
                  hdr_d[0] = v8; hdr_d[1] = 8'h00; hdr_d[2] = 8'h00;
                  hdr_d[3] = tcyl_q; hdr_d[4] = head_q; hdr_d[5] = sec_q;
                  hdr_d[6] = size_q;
                  base_d = rd_addr[ImageAw-1:0];
                  sec_inc = sec_q + 8'd1;
                  if (sec_inc == 8'(SectorsPerTrack)) begin
                    sec_d = 8'd0; tcyl_d = tcyl_q + 8'd1;
                  end else begin
                    sec_d = sec_inc;
                  end
                  ract_d = 1'b1; rrem_d = 10'(HeaderLen + SectorBytes); rpos_d = 10'd0;
                  ms_d = {4'h0, ms_q[3:0]} | MS_RQM | MS_DIO | MS_BUSY;
                end
              end
              CMD_RECAL: begin
                if (pc_q == 4'd1) begin
                  unit_d = wb[1:0]; tcyl_d = 8'd0; sec_d = 8'd0;
                end
                pc_d = pcn;
                if (pcn == 4'd2) begin
                  pc_d = 4'd0; pcyl_d = 8'd0;
                  st0_d = {5'd0, head_q[0], unit_d} | ST_SEEK_END;
                end
              end
              CMD_READ_ID: begin
                if (pc_q == 4'd1) begin
                  head_d = {7'd0, wb[2]}; unit_d = wb[1:0];
                end
                pc_d = pcn;
                if (pcn == 4'd2) begin
                  pc_d = 4'd0;
                  v8 = {5'd0, head_d[0], unit_d};
                  st0_d = v8;
                  hdr_d[0] = v8; hdr_d[1] = 8'h00; hdr_d[2] = 8'h00;
                  hdr_d[3] = tcyl_q; hdr_d[4] = head_d; hdr_d[5] = sec_q;
                  hdr_d[6] = size_q;
                  ract_d = 1'b1; rrem_d = 10'(HeaderLen); rpos_d = 10'd0;
                  ms_d = {4'h0, ms_q[3:0]} | MS_RQM | MS_DIO | MS_BUSY;
                end
              end
              CMD_SEEK: begin
                if (pc_q == 4'd1) begin
                  head_d = {7'd0, wb[2]}; unit_d = wb[1:0];
                end
                if (pc_q == 4'd2) begin
                  tcyl_d = wb; sec_d = 8'd0; pcyl_d = wb;
                end
                pc_d = pcn;
                if (pcn == 4'd3) begin
                  pc_d = 4'd0; st0_d = {5'd0, dbits} | ST_SEEK_END;
                end
              end
              default: ;
            endcase
          end
        end
        OP_READ_DATA: begin
          new_res = 1'b1;
          if (ract_q) begin
            if (rpos_q < 10'(HeaderLen)) new_byte = hdr_q[rpos_q[2:0]];
            else new_fetch = 1'b1;
            rpos_d = rpos_q + 10'd1;
            rrem_d = rrem_q - 10'd1;
            if (rrem_d == 10'd0) begin
              ract_d = 1'b0; ms_d = {4'h0, ms_q[3:0]} | MS_RQM;
            end
          end
        end
        OP_READ_STATUS: begin
          new_res = 1'b1; new_byte = ms_q;
        end
        default: ;
      endcase
    end
  end

  assign fwd_hit = acc && op == OP_LOAD_IMAGE && waddr == raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; cmd_q <= '0; tim_q <= '0; head_q <= '0; unit_q <= '0;
      pcyl_q <= '0; tcyl_q <= '0; sec_q <= '0; size_q <= 8'd2; teg_q <= '0;
      st0_q <= '0; st3_q <= '0; ms_q <= MS_RQM; opp_q <= 1'b0; ract_q <= 1'b0;
      rrem_q <= '0; rpos_q <= '0; base_q <= '0;
      ov_q <= 1'b0; ofetch_q <= 1'b0;
    end else begin
      pc_q <= pc_d; cmd_q <= cmd_d; tim_q <= tim_d; head_q <= head_d; unit_q <= unit_d;
      pcyl_q <= pcyl_d; tcyl_q <= tcyl_d; sec_q <= sec_d; size_q <= size_d;
      teg_q <= teg_d; st0_q <= st0_d; st3_q <= st3_d; ms_q <= ms_d; opp_q <= opp_d;
      ract_q <= ract_d; rrem_q <= rrem_d; rpos_q <= rpos_d; base_q <= base_d;
      if (acc && new_res) begin
        ov_q <= 1'b1; ofetch_q <= new_fetch;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
      // capture RAM data once so later reads of the same RAM port cannot disturb it
      if (ofetch_q && !(acc && new_res)) ofetch_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    fwd_hit_q <= fwd_hit;
    fwd_q <= wb;
    if (acc && new_res) obyte_q <= new_byte;
    else if (ofetch_q) obyte_q <= fwd_hit_q ? fwd_q : ram_rd;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = ofetch_q ? (fwd_hit_q ? fwd_q : ram_rd) : obyte_q;

  // a result is never dropped while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
  // result counter drains exactly when the run ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ract_q |-> rrem_q != 10'd0) else $error("active with no bytes left");
  // parameter counter never exceeds a read data parameter list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= 4'd8) else $error("parameter count overrun");

endmodule
